FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RCFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcfa port check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RCFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcfa port check failed");

`endif

FILE: hdl/rcfa_pkg.sv
`default_nettype none

package rcfa_pkg;

    localparam int DIM_W       = 13;
    localparam int LEN_W       = 18;
    localparam int PIX_W       = 16;
    localparam int RADDR_W     = 16;
    localparam int POS_W       = 17;
    localparam int SCALE_W     = 11;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int DIV_NUM_W   = 21;
    localparam int DIV_DEN_W   = 13;
    localparam int DIV_CNT_W   = 5;
    localparam int SUM_W       = DIV_NUM_W + 1;
    localparam int PANEL_SHIFT = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SCALE_W-1:0] SCALE_CAP = 11'd1024;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HDR    = 2'd1,
        ST_OUT_OF_SEQ = 2'd2,
        ST_OVER_CAP   = 2'd3
    } status_t;

    typedef enum logic {
        KIND_CHUNK = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_READ  = 1'b1
    } command_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PANEL_WIDTH  = 1'b0,
        REG_PANEL_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_HDR = 2'd0,
        DIV_SX  = 2'd1,
        DIV_SY  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic               command;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [DIM_W-1:0]   start_row;
        logic [LEN_W-1:0]   chunk_bytes;
        logic [PIX_W-1:0]   pixel;
        logic               last_in_chunk;
        logic [RADDR_W-1:0] read_address;
    } chunk_item_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic               frame_complete;
        logic [SCALE_W-1:0] fit_scale;
        logic [DIM_W-1:0]   rows_assembled;
        logic               frame_ready;
        logic [PIX_W-1:0]   read_pixel;
        logic               read_valid;
    } result_item_t;

    typedef struct packed {
        logic     latch;
        logic     stream_wr;
        logic     hdr_load;
        logic     div_start;
        div_sel_t div_sel;
        logic     judge;
        logic     clr_wr;
        logic     first_wr;
        logic     sx_save;
        logic     sy_save;
        logic     emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_cmd_read;
        logic in_last;
        logic lat_last;
        logic in_chunk;
        logic dim_ok;
        logic div_done;
        logic need_clear;
        logic complete_now;
        logic complete;
        logic clr_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/rcfa_channels.sv
`default_nettype none

interface rcfa_chunk_if import rcfa_pkg::*;;
    logic               valid;
    logic               ready;
    logic               command;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [DIM_W-1:0]   start_row;
    logic [LEN_W-1:0]   chunk_bytes;
    logic [PIX_W-1:0]   pixel;
    logic               last_in_chunk;
    logic [RADDR_W-1:0] read_address;

    modport source (
        output valid, command, frame_width, frame_height, start_row,
        output chunk_bytes, pixel, last_in_chunk, read_address,
        input  ready
    );
    modport sink (
        input  valid, command, frame_width, frame_height, start_row,
        input  chunk_bytes, pixel, last_in_chunk, read_address,
        output ready
    );
endinterface

interface rcfa_result_if import rcfa_pkg::*;;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [1:0]         status;
    logic               frame_complete;
    logic [SCALE_W-1:0] fit_scale;
    logic [DIM_W-1:0]   rows_assembled;
    logic               frame_ready;
    logic [PIX_W-1:0]   read_pixel;
    logic               read_valid;

    modport source (
        output valid, kind, status, frame_complete, fit_scale,
        output rows_assembled, frame_ready, read_pixel, read_valid,
        input  ready
    );
    modport sink (
        input  valid, kind, status, frame_complete, fit_scale,
        input  rows_assembled, frame_ready, read_pixel, read_valid,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/row_chunk_frame_assembler.sv
// Row chunk frame assembler for RGB565 frames.
// chunk: request channel (valid/ready). command 0 carries one pixel of a row
//   chunk with the chunk header repeated; command 1 reads one stored pixel.
// result: one result per read and one per chunk item flagged last_in_chunk.
// wr_en/wr_index/wr_data: panel width (index 0) and height (index 1);
//   the user must write them only while the block is idle; not enforced.
// Throughput: pixels after the first of a chunk are taken one per cycle.
// The first item of a chunk runs the header check through a shared
//   serial divider when the frame size is valid. A new frame size adds
//   a clear sweep of the width*height store entries, one per cycle. The
//   chunk that completes the frame adds two more divider passes for the
//   fit scale.
// A read goes through a registered store read, then the result register.
// A last item or read waits while the result register is still full, so a
//   stalled receiver holds off the channel once one result is pending.
// Reset clears progress, stored size, ready flag and the output valid and
//   sets both panel registers to 240; store contents are undefined until the
//   first frame size clears them.
`default_nettype none

module row_chunk_frame_assembler import rcfa_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_PIXELS = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rcfa_chunk_if.sink           chunk,
    rcfa_result_if.source        result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DIM_W-1:0]     wr_data
);

    chunk_item_t  item;
    result_item_t res;
    ctrl_cmd_t    cmd;
    dp_stat_t     stat;
    logic         req_ready;
    logic         res_valid;

    always_comb
    begin
        item.command       = chunk.command;
        item.frame_width   = chunk.frame_width;
        item.frame_height  = chunk.frame_height;
        item.start_row     = chunk.start_row;
        item.chunk_bytes   = chunk.chunk_bytes;
        item.pixel         = chunk.pixel;
        item.last_in_chunk = chunk.last_in_chunk;
        item.read_address  = chunk.read_address;
    end

    assign chunk.ready = req_ready;

    rcfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (chunk.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rcfa_datapath #(
        .MAX_DIM    (MAX_DIM),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .res_ready (result.ready),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result.valid          = res_valid;
    assign result.kind           = res.kind;
    assign result.status         = res.status;
    assign result.frame_complete = res.frame_complete;
    assign result.fit_scale      = res.fit_scale;
    assign result.rows_assembled = res.rows_assembled;
    assign result.frame_ready    = res.frame_ready;
    assign result.read_pixel     = res.read_pixel;
    assign result.read_valid     = res.read_valid;

endmodule

`default_nettype wire

FILE: hdl/rcfa_div.sv
`default_nettype none

module rcfa_div import rcfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot,
    output logic [DIV_DEN_W-1:0] rem
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_NUM_W-1:0] quot_next;
    logic [DIV_DEN_W-1:0] rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DIV_NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = shifted >= {1'b0, den_reg};
        rem_next  = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
        quot_next = {quot_reg[DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: hdl/rcfa_datapath.sv
`default_nettype none

module rcfa_datapath import rcfa_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_PIXELS = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chunk_item_t          item,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DIM_W-1:0]     wr_data,
    input  logic                 res_ready,
    output logic                 res_valid,
    output result_item_t         res
);

    localparam int                AW        = $clog2(MAX_PIXELS);
    localparam logic [DIM_W-1:0]  MAX_DIM_C = DIM_W'(MAX_DIM);
    localparam logic [PROD_W-1:0] MAX_PIX_C = PROD_W'(MAX_PIXELS);

    chunk_item_t          lat_reg;
    logic [DIM_W-1:0]     panel_w_reg;
    logic [DIM_W-1:0]     panel_h_reg;
    logic [DIM_W-1:0]     stored_w_reg;
    logic [DIM_W-1:0]     stored_h_reg;
    logic [PROD_W-1:0]    stored_n_reg;
    logic [DIM_W-1:0]     next_row_reg;
    logic                 ready_flag_reg;
    logic                 in_chunk_reg;
    status_t              verdict_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pixels_reg;
    logic                 res_valid_reg;

    logic [PROD_W-1:0]    n_hdr_reg;
    logic [AW-1:0]        base_reg;
    logic [AW-1:0]        wr_addr_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 complete_reg;
    logic [DIM_W-1:0]     row_end_reg;
    logic [DIV_NUM_W-1:0] sx_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [PIX_W-1:0]     rd_data_reg;
    result_item_t         res_reg;

    logic [PIX_W-1:0]     mem [MAX_PIXELS];

    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [DIV_DEN_W-1:0] div_rem;

    logic                 dim_ok;
    logic [SUM_W-1:0]     row_sum;
    logic                 len_bad;
    logic                 over_run;
    logic                 seq_break;
    logic                 resize;
    status_t              verdict_now;
    logic                 restart;

    logic                 pix_take;
    logic                 wr_take;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [PIX_W-1:0]     mem_wdata;
    logic [PROD_W-1:0]    rd_ext;
    logic [PROD_W-1:0]    lat_rd_ext;
    logic                 rd_ok;

    logic                 fc;
    logic [DIM_W-1:0]     next_row_next;
    logic                 ready_flag_next;
    result_item_t         res_next;
    logic [DIV_NUM_W-1:0] min_scale;

    rcfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_comb
    begin
        case (cmd.div_sel)
            DIV_HDR:
            begin
                div_num = DIV_NUM_W'(lat_reg.chunk_bytes[LEN_W-1:1]);
                div_den = lat_reg.frame_width;
            end
            DIV_SX:
            begin
                div_num = DIV_NUM_W'({panel_w_reg, {PANEL_SHIFT{1'b0}}});
                div_den = stored_w_reg;
            end
            DIV_SY:
            begin
                div_num = DIV_NUM_W'({panel_h_reg, {PANEL_SHIFT{1'b0}}});
                div_den = stored_h_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '1;
            end
        endcase
    end

    // header checks; len/2 divided by width gives the row count
    always_comb
    begin
        dim_ok    = (lat_reg.frame_width != '0) && (lat_reg.frame_height != '0)
                    && (lat_reg.frame_width <= MAX_DIM_C)
                    && (lat_reg.frame_height <= MAX_DIM_C);
        row_sum   = SUM_W'(lat_reg.start_row) + SUM_W'(div_quot);
        len_bad   = (lat_reg.chunk_bytes == '0) || lat_reg.chunk_bytes[0]
                    || (div_rem != '0);
        over_run  = row_sum > SUM_W'(lat_reg.frame_height);
        seq_break = lat_reg.start_row != next_row_reg;
        resize    = (lat_reg.frame_width != stored_w_reg)
                    || (lat_reg.frame_height != stored_h_reg);
        if (!dim_ok || len_bad || over_run)
            verdict_now = ST_BAD_HDR;
        else if (seq_break && (lat_reg.start_row != '0))
            verdict_now = ST_OUT_OF_SEQ;
        else if (resize && (n_hdr_reg > MAX_PIX_C))
            verdict_now = ST_OVER_CAP;
        else
            verdict_now = ST_OK;
        // a row-0 restart drops progress even when the chunk is then over capacity
        restart = seq_break && ((verdict_now == ST_OK) || (verdict_now == ST_OVER_CAP));
    end

    always_comb
    begin
        pix_take  = (verdict_reg == ST_OK) && (pos_reg < pixels_reg);
        wr_take   = (cmd.stream_wr || cmd.first_wr) && pix_take;
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = item.pixel;
        if (cmd.clr_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.stream_wr)
        begin
            mem_we    = pix_take;
            mem_wdata = item.pixel;
        end
        else if (cmd.first_wr)
        begin
            mem_we    = pix_take;
            mem_wdata = lat_reg.pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    assign rd_ext = PROD_W'(item.read_address);

    always_ff @(posedge clk)
    begin
        if (cmd.latch && (item.command == CMD_READ))
            rd_data_reg <= mem[rd_ext[AW-1:0]];
    end

    always_comb
    begin
        lat_rd_ext = PROD_W'(lat_reg.read_address);
        rd_ok      = (lat_rd_ext < stored_n_reg) && (lat_rd_ext < MAX_PIX_C);
        fc         = complete_reg;
        if (verdict_reg == ST_OK)
            next_row_next = complete_reg ? '0 : row_end_reg;
        else
            next_row_next = next_row_reg;
        ready_flag_next = ready_flag_reg || fc;

        res_next = '0;
        if (lat_reg.command == CMD_READ)
        begin
            res_next.kind           = KIND_READ;
            res_next.status         = ST_OK;
            res_next.rows_assembled = next_row_reg;
            res_next.frame_ready    = ready_flag_reg;
            res_next.read_valid     = rd_ok;
            res_next.read_pixel     = rd_ok ? rd_data_reg : '0;
        end
        else
        begin
            res_next.kind           = KIND_CHUNK;
            res_next.status         = verdict_reg;
            res_next.frame_complete = fc;
            res_next.fit_scale      = fc ? scale_reg : '0;
            res_next.rows_assembled = next_row_next;
            res_next.frame_ready    = ready_flag_next;
        end

        min_scale = (sx_reg < div_quot) ? sx_reg : div_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_w_reg    <= DIM_W'(240);
            panel_h_reg    <= DIM_W'(240);
            stored_w_reg   <= '0;
            stored_h_reg   <= '0;
            stored_n_reg   <= '0;
            next_row_reg   <= '0;
            ready_flag_reg <= 1'b0;
            in_chunk_reg   <= 1'b0;
            verdict_reg    <= ST_OK;
            pos_reg        <= '0;
            pixels_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_index == REG_PANEL_WIDTH))
                panel_w_reg <= wr_data;
            if (wr_en && (wr_index == REG_PANEL_HEIGHT))
                panel_h_reg <= wr_data;

            if (cmd.judge)
            begin
                verdict_reg  <= verdict_now;
                in_chunk_reg <= 1'b1;
                pos_reg      <= '0;
                pixels_reg   <= (verdict_now == ST_OK) ?
                                lat_reg.chunk_bytes[LEN_W-1:1] : '0;
                if (restart)
                    next_row_reg <= '0;
                if ((verdict_now == ST_OK) && resize)
                begin
                    stored_w_reg   <= lat_reg.frame_width;
                    stored_h_reg   <= lat_reg.frame_height;
                    stored_n_reg   <= n_hdr_reg;
                    ready_flag_reg <= 1'b0;
                end
            end

            if (wr_take)
                pos_reg <= pos_reg + 1'b1;

            if (cmd.emit && (lat_reg.command == CMD_PIXEL))
            begin
                next_row_reg   <= next_row_next;
                ready_flag_reg <= ready_flag_next;
                in_chunk_reg   <= 1'b0;
            end

            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            lat_reg <= item;
        if (cmd.hdr_load)
        begin
            n_hdr_reg <= PROD_W'(lat_reg.frame_width) * PROD_W'(lat_reg.frame_height);
            base_reg  <= AW'(PROD_W'(lat_reg.start_row) * PROD_W'(lat_reg.frame_width));
        end
        if (cmd.judge)
        begin
            complete_reg <= (verdict_now == ST_OK)
                            && (row_sum == SUM_W'(lat_reg.frame_height));
            row_end_reg  <= row_sum[DIM_W-1:0];
            wr_addr_reg  <= base_reg;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (wr_take)
                wr_addr_reg <= wr_addr_reg + 1'b1;
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
        if (cmd.sx_save)
            sx_reg <= div_quot;
        if (cmd.sy_save)
            scale_reg <= (min_scale > DIV_NUM_W'(SCALE_CAP)) ?
                         SCALE_CAP : min_scale[SCALE_W-1:0];
        if (cmd.emit)
            res_reg <= res_next;
    end

    always_comb
    begin
        stat.in_cmd_read  = item.command == CMD_READ;
        stat.in_last      = item.last_in_chunk;
        stat.lat_last     = lat_reg.last_in_chunk;
        stat.in_chunk     = in_chunk_reg;
        stat.dim_ok       = dim_ok;
        stat.div_done     = div_done;
        stat.need_clear   = (verdict_now == ST_OK) && resize;
        stat.complete_now = (verdict_now == ST_OK)
                            && (row_sum == SUM_W'(lat_reg.frame_height));
        stat.complete     = complete_reg;
        stat.clr_last     = PROD_W'(clr_cnt_reg) == (stored_n_reg - PROD_W'(1));
        stat.out_free     = !res_valid_reg || res_ready;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: hdl/rcfa_ctrl.sv
`default_nettype none

module rcfa_ctrl import rcfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HDR   = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_JUDGE = 9'b000001000,
        S_CLEAR = 9'b000010000,
        S_SX    = 9'b000100000,
        S_SY    = 9'b001000000,
        S_FIRST = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc;

    assign req_ready = state_reg == S_IDLE;
    assign acc       = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_HDR;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.latch = 1'b1;
                    if (stat.in_cmd_read)
                        state_next = S_EMIT;
                    else if (stat.in_chunk)
                    begin
                        cmd.stream_wr = 1'b1;
                        state_next    = stat.in_last ? S_EMIT : S_IDLE;
                    end
                    else
                        state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                cmd.hdr_load = 1'b1;
                if (stat.dim_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_JUDGE;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                cmd.judge = 1'b1;
                if (stat.need_clear)
                    state_next = S_CLEAR;
                else if (stat.complete_now)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SX;
                    state_next    = S_SX;
                end
                else
                    state_next = S_FIRST;
            end
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    if (stat.complete)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_SX;
                        state_next    = S_SX;
                    end
                    else
                        state_next = S_FIRST;
                end
            end
            S_SX:
            begin
                cmd.div_sel = DIV_SX;
                if (stat.div_done)
                begin
                    cmd.sx_save   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SY;
                    state_next    = S_SY;
                end
            end
            S_SY:
            begin
                cmd.div_sel = DIV_SY;
                if (stat.div_done)
                begin
                    cmd.sy_save = 1'b1;
                    state_next  = S_FIRST;
                end
            end
            S_FIRST:
            begin
                cmd.first_wr = 1'b1;
                state_next   = stat.lat_last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hdl/rcfa_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rcfa_checker import rcfa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic               res_kind,
    input logic [1:0]         res_status,
    input logic               res_frame_complete,
    input logic [SCALE_W-1:0] res_fit_scale,
    input logic [DIM_W-1:0]   res_rows_assembled,
    input logic               res_frame_ready,
    input logic [PIX_W-1:0]   res_read_pixel,
    input logic               res_read_valid
);

    `RCFA_ASSERT_NEXT(a_result_held, res_valid && !res_ready,
        res_valid && $stable(res_kind) && $stable(res_status)
        && $stable(res_fit_scale) && $stable(res_read_pixel)
        && $stable(res_rows_assembled))

    `RCFA_ASSERT_NOW(a_read_clean, res_valid && (res_kind == KIND_READ),
        (res_status == ST_OK) && !res_frame_complete && (res_fit_scale == '0))

    `RCFA_ASSERT_NOW(a_chunk_clean, res_valid && (res_kind == KIND_CHUNK),
        !res_read_valid && (res_read_pixel == '0))

    `RCFA_ASSERT_NOW(a_complete_state, res_valid && res_frame_complete,
        (res_rows_assembled == '0) && res_frame_ready && (res_status == ST_OK))

    `RCFA_ASSERT_NOW(a_scale_on_complete, res_valid && (res_fit_scale != '0),
        res_frame_complete && (res_fit_scale <= SCALE_CAP))

endmodule

bind row_chunk_frame_assembler rcfa_checker u_rcfa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .res_kind           (result.kind),
    .res_status         (result.status),
    .res_frame_complete (result.frame_complete),
    .res_fit_scale      (result.fit_scale),
    .res_rows_assembled (result.rows_assembled),
    .res_frame_ready    (result.frame_ready),
    .res_read_pixel     (result.read_pixel),
    .res_read_valid     (result.read_valid)
);

`default_nettype wire
